### src/qmn_pkg.sv
package qmn_pkg;

    localparam int unsigned COMP_W    = 32;
    localparam int unsigned SCALE_TOP = 30;

    typedef struct packed {
        logic signed [COMP_W-1:0] a_w;
        logic signed [COMP_W-1:0] a_x;
        logic signed [COMP_W-1:0] a_y;
        logic signed [COMP_W-1:0] a_z;
        logic signed [COMP_W-1:0] b_w;
        logic signed [COMP_W-1:0] b_x;
        logic signed [COMP_W-1:0] b_y;
        logic signed [COMP_W-1:0] b_z;
    } in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] p_w;
        logic signed [COMP_W-1:0] p_x;
        logic signed [COMP_W-1:0] p_y;
        logic signed [COMP_W-1:0] p_z;
        logic                     zero_norm;
    } out_t;

    // scaled magnitudes and signs carried alongside the square root
    typedef struct packed {
        logic [3:0][SCALE_TOP-1:0] mag;
        logic [3:0]                neg;
        logic                      zero;
    } sqrt_side_t;

endpackage

### src/quaternion_multiply_normalize.sv
// Normalised Hamilton product a*b of two quaternions in signed fixed point
// (32-bit components, FRACTION_BITS fraction bits). Each transaction on the s_
// channel yields exactly one transaction on the m_ channel carrying the unit
// quaternion a*b/|a*b|; a zero product gives zero components with zero_norm set.
// The datapath is a fully pipelined chain: sixteen 32x32 multipliers, term sums,
// magnitude/sign split, leading-one detect, normalising shift, squares and their
// sum, a 32-stage integer square root (one result bit per stage) and a
// FRACTION_BITS+1 stage restoring divider per component (one quotient bit per
// stage). One transaction is accepted every clock while the pipe advances.
// The whole pipe advances together whenever the output register is empty or
// being taken, so s_ready follows m_ready and a stall drops or repeats nothing.
module quaternion_multiply_normalize #(
    parameter int unsigned FRACTION_BITS = 30
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  qmn_pkg::in_t        s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output qmn_pkg::out_t       m_data
);

    localparam int unsigned ST     = qmn_pkg::SCALE_TOP;
    localparam int unsigned SQ_N   = 32;                    // square root stages
    localparam int unsigned DIV_N  = FRACTION_BITS + 1;     // quotient bits
    localparam int unsigned NUM_W  = ST + 1 + FRACTION_BITS; // dividend width
    localparam int unsigned NORM_W = 31;
    localparam int unsigned RES_W  = 63;

    typedef struct packed {
        logic [3:0]        neg;
        logic              zero;
        logic [NORM_W-1:0] norm;
    } div_side_t;

    // whole pipe moves when the output register is free or being drained
    logic en;
    logic m_valid_reg;
    qmn_pkg::out_t out_reg, out_next;

    assign en      = m_ready | ~m_valid_reg;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // stage 1: input register
    logic         v1_reg;
    qmn_pkg::in_t in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
        if (en) begin
            in_reg <= s_data;
        end
    end

    // stage 2: sixteen products, each divided by four rounding down
    logic               v2_reg;
    logic signed [61:0] prod_reg  [16];
    logic signed [61:0] prod_next [16];
    logic signed [31:0] aa [4];
    logic signed [31:0] bb [4];

    assign aa[0] = in_reg.a_w;
    assign aa[1] = in_reg.a_x;
    assign aa[2] = in_reg.a_y;
    assign aa[3] = in_reg.a_z;
    assign bb[0] = in_reg.b_w;
    assign bb[1] = in_reg.b_x;
    assign bb[2] = in_reg.b_y;
    assign bb[3] = in_reg.b_z;

    always_comb begin
        logic signed [63:0] full;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                full = 64'(aa[i]) * 64'(bb[j]);
                prod_next[i*4+j] = full[63:2];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    // stage 3: Hamilton product components
    logic               v3_reg;
    logic signed [63:0] sum_reg  [4];
    logic signed [63:0] sum_next [4];
    logic signed [63:0] px [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            px[i] = 64'(prod_reg[i]);
        end
        sum_next[0] = px[0]  - px[5]  - px[10] - px[15];
        sum_next[1] = px[1]  + px[4]  + px[11] - px[14];
        sum_next[2] = px[2]  - px[7]  + px[8]  + px[13];
        sum_next[3] = px[3]  + px[6]  - px[9]  + px[12];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            sum_reg <= sum_next;
        end
    end

    // stage 4: split into sign and magnitude, or all magnitudes together
    logic        v4_reg;
    logic [62:0] mag_reg  [4];
    logic [62:0] mag_next [4];
    logic [3:0]  neg_reg, neg_next;
    logic [62:0] orall_reg, orall_next;

    always_comb begin
        logic signed [63:0] abs_v;
        orall_next = '0;
        for (int i = 0; i < 4; i++) begin
            neg_next[i] = sum_reg[i][63];
            abs_v       = neg_next[i] ? -sum_reg[i] : sum_reg[i];
            mag_next[i] = abs_v[62:0];
            orall_next  = orall_next | mag_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            orall_reg <= orall_next;
        end
    end

    // stage 5: bit length of the largest magnitude
    // (the or of all magnitudes has the same leading one as the maximum)
    logic        v5_reg;
    logic [62:0] mag5_reg [4];
    logic [3:0]  neg5_reg;
    logic        zero5_reg, zero5_next;
    logic [5:0]  bl_reg, bl_next;

    always_comb begin
        bl_next = '0;
        for (int i = 0; i < 63; i++) begin
            if (orall_reg[i]) begin
                bl_next = 6'(i + 1);
            end
        end
        zero5_next = (orall_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
        if (en) begin
            mag5_reg  <= mag_reg;
            neg5_reg  <= neg_reg;
            zero5_reg <= zero5_next;
            bl_reg    <= bl_next;
        end
    end

    // stage 6: common shift so the largest magnitude sits in [2^29, 2^30)
    logic            v6_reg;
    logic [ST-1:0]   smag_reg  [4];
    logic [ST-1:0]   smag_next [4];
    logic [3:0]      neg6_reg;
    logic            zero6_reg;

    always_comb begin
        logic [62:0] sh;
        for (int i = 0; i < 4; i++) begin
            if (bl_reg > 6'(ST)) begin
                sh = mag5_reg[i] >> (bl_reg - 6'(ST));
            end else begin
                sh = mag5_reg[i] << (6'(ST) - bl_reg);
            end
            smag_next[i] = sh[ST-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
        if (en) begin
            smag_reg  <= smag_next;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    // stage 7: squares
    logic            v7_reg;
    logic [2*ST-1:0] sq_reg [4];
    logic [ST-1:0]   smag7_reg [4];
    logic [3:0]      neg7_reg;
    logic            zero7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                sq_reg[i] <= (2*ST)'(smag_reg[i]) * (2*ST)'(smag_reg[i]);
            end
            smag7_reg <= smag_reg;
            neg7_reg  <= neg6_reg;
            zero7_reg <= zero6_reg;
        end
    end

    // stage 8: sum of squares feeds square root entry (index 0)
    logic                sq_vld_reg [SQ_N+1];
    logic [2*ST+1:0]     sq_v_reg   [SQ_N+1];
    logic [RES_W-1:0]    sq_res_reg [SQ_N+1];
    qmn_pkg::sqrt_side_t sq_sb_reg  [SQ_N+1];
    qmn_pkg::sqrt_side_t sb_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sb_next.mag[i] = smag7_reg[i];
        end
        sb_next.neg  = neg7_reg;
        sb_next.zero = zero7_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (en) begin
            sq_vld_reg[0] <= v7_reg;
        end
        if (en) begin
            sq_v_reg[0]   <= (2*ST+2)'(sq_reg[0]) + (2*ST+2)'(sq_reg[1])
                           + (2*ST+2)'(sq_reg[2]) + (2*ST+2)'(sq_reg[3]);
            sq_res_reg[0] <= '0;
            sq_sb_reg[0]  <= sb_next;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam logic [RES_W-1:0] BIT = RES_W'(1) << (62 - 2*k);
        logic [RES_W-1:0] trial;
        logic [RES_W-1:0] v_ext;
        logic [2*ST+1:0]  v_next;
        logic [RES_W-1:0] res_next;

        always_comb begin
            trial = sq_res_reg[k] + BIT;
            v_ext = RES_W'(sq_v_reg[k]);
            if (v_ext >= trial) begin
                v_next   = (2*ST+2)'(v_ext - trial);
                res_next = (sq_res_reg[k] >> 1) + BIT;
            end else begin
                v_next   = sq_v_reg[k];
                res_next = sq_res_reg[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
            if (en) begin
                sq_v_reg[k+1]   <= v_next;
                sq_res_reg[k+1] <= res_next;
                sq_sb_reg[k+1]  <= sq_sb_reg[k];
            end
        end
    end

    // divider entry: dividend mag*2^F + norm/2, top bits form the first remainder
    logic              dv_vld_reg [DIV_N+1];
    logic [NORM_W-1:0] dv_rem_reg [DIV_N+1][4];
    logic [DIV_N-1:0]  dv_low_reg [DIV_N+1][4];
    logic [DIV_N-1:0]  dv_q_reg   [DIV_N+1][4];
    div_side_t         dv_sb_reg  [DIV_N+1];

    logic [NORM_W-1:0] norm_w;
    logic [NUM_W-1:0]  num   [4];
    div_side_t         dsb_next;

    assign norm_w = sq_res_reg[SQ_N][NORM_W-1:0];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            num[i] = (NUM_W'(sq_sb_reg[SQ_N].mag[i]) << FRACTION_BITS)
                   + NUM_W'(norm_w >> 1);
        end
        dsb_next.neg  = sq_sb_reg[SQ_N].neg;
        dsb_next.zero = sq_sb_reg[SQ_N].zero;
        dsb_next.norm = norm_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= sq_vld_reg[SQ_N];
        end
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                dv_rem_reg[0][i] <= NORM_W'(num[i][NUM_W-1:DIV_N]);
                dv_low_reg[0][i] <= num[i][DIV_N-1:0];
                dv_q_reg[0][i]   <= '0;
            end
            dv_sb_reg[0] <= dsb_next;
        end
    end

    // restoring division, one quotient bit per stage, four lanes
    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        logic [NORM_W-1:0] rem_next [4];
        logic [DIV_N-1:0]  q_next   [4];

        always_comb begin
            logic [NORM_W:0] r2;
            for (int i = 0; i < 4; i++) begin
                r2 = {dv_rem_reg[k][i], dv_low_reg[k][i][DIV_N-1]};
                if (r2 >= {1'b0, dv_sb_reg[k].norm}) begin
                    rem_next[i] = NORM_W'(r2 - {1'b0, dv_sb_reg[k].norm});
                    q_next[i]   = {dv_q_reg[k][i][DIV_N-2:0], 1'b1};
                end else begin
                    rem_next[i] = r2[NORM_W-1:0];
                    q_next[i]   = {dv_q_reg[k][i][DIV_N-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
            if (en) begin
                for (int i = 0; i < 4; i++) begin
                    dv_rem_reg[k+1][i] <= rem_next[i];
                    dv_low_reg[k+1][i] <= dv_low_reg[k][i] << 1;
                    dv_q_reg[k+1][i]   <= q_next[i];
                end
                dv_sb_reg[k+1] <= dv_sb_reg[k];
            end
        end
    end

    // output register: apply signs, force zero on a null product
    always_comb begin
        logic signed [31:0] p [4];
        logic signed [31:0] q;
        for (int i = 0; i < 4; i++) begin
            q = 32'(dv_q_reg[DIV_N][i]);
            if (dv_sb_reg[DIV_N].zero) begin
                p[i] = '0;
            end else if (dv_sb_reg[DIV_N].neg[i]) begin
                p[i] = -q;
            end else begin
                p[i] = q;
            end
        end
        out_next.p_w       = p[0];
        out_next.p_x       = p[1];
        out_next.p_y       = p[2];
        out_next.p_z       = p[3];
        out_next.zero_norm = dv_sb_reg[DIV_N].zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_vld_reg[DIV_N];
        end
        if (en) begin
            out_reg <= out_next;
        end
    end

endmodule

### src/qmn_checker.sv
module qmn_checker #(
    parameter int unsigned FRACTION_BITS = 30
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input qmn_pkg::out_t m_data,
    input logic          m_valid,
    input logic          m_ready
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;

    // held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_norm |->
            m_data.p_w == 0 && m_data.p_x == 0 && m_data.p_y == 0 && m_data.p_z == 0)
        else $error("zero norm with nonzero component");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_data.p_w <= ONE && m_data.p_w >= -ONE &&
            m_data.p_x <= ONE && m_data.p_x >= -ONE &&
            m_data.p_y <= ONE && m_data.p_y >= -ONE &&
            m_data.p_z <= ONE && m_data.p_z >= -ONE)
        else $error("component beyond unit magnitude");

    // stalled output backs up into the input side
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while pipe stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind quaternion_multiply_normalize qmn_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_qmn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

### test/quaternion_multiply_normalize_tb.sv
module quaternion_multiply_normalize_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAC = 30;
    localparam int unsigned LATENCY = FRAC + 42;
    localparam longint CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    qmn_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    qmn_pkg::out_t m_data;

    int unsigned errors = 0;
    longint cycles = 0;
    bit no_idle = 1'b0;      // long stretch with no gaps on either side
    bit hold_off = 1'b0;     // receiver held off to fill the pipe
    qmn_pkg::out_t rotation_queue[$];

    quaternion_multiply_normalize #(.FRACTION_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // timeout guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // floor division by four of an exact 64-bit product
    function automatic longint quarter_product(logic signed [31:0] p, logic signed [31:0] q);
        longint prod;
        prod = longint'(p) * longint'(q);
        return prod >>> 2;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // normalised hamilton product, bit exact
    function automatic qmn_pkg::out_t unit_product(qmn_pkg::in_t q);
        longint comp[4];
        longint unsigned mag[4];
        bit neg[4];
        longint unsigned biggest, sum, norm, quo;
        int blen;
        qmn_pkg::out_t r;
        comp[0] = quarter_product(q.a_w, q.b_w) - quarter_product(q.a_x, q.b_x)
                - quarter_product(q.a_y, q.b_y) - quarter_product(q.a_z, q.b_z);
        comp[1] = quarter_product(q.a_w, q.b_x) + quarter_product(q.a_x, q.b_w)
                + quarter_product(q.a_y, q.b_z) - quarter_product(q.a_z, q.b_y);
        comp[2] = quarter_product(q.a_w, q.b_y) - quarter_product(q.a_x, q.b_z)
                + quarter_product(q.a_y, q.b_w) + quarter_product(q.a_z, q.b_x);
        comp[3] = quarter_product(q.a_w, q.b_z) + quarter_product(q.a_x, q.b_y)
                - quarter_product(q.a_y, q.b_x) + quarter_product(q.a_z, q.b_w);
        biggest = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = comp[i] < 0;
            mag[i] = neg[i] ? longint'(-comp[i]) : longint'(comp[i]);
            if (mag[i] > biggest) biggest = mag[i];
        end
        r = '0;
        if (biggest == 0) begin
            r.zero_norm = 1'b1;
            return r;
        end
        blen = 0;
        while ((biggest >> blen) != 0) blen++;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            if (blen > qmn_pkg::SCALE_TOP) mag[i] >>= (blen - qmn_pkg::SCALE_TOP);
            else mag[i] <<= (qmn_pkg::SCALE_TOP - blen);
            sum += mag[i] * mag[i];
        end
        norm = int_sqrt(sum);
        for (int i = 0; i < 4; i++) begin
            quo = ((mag[i] << FRAC) + (norm >> 1)) / norm;
            comp[i] = neg[i] ? -longint'(quo) : longint'(quo);
        end
        r.p_w = comp[0][31:0];
        r.p_x = comp[1][31:0];
        r.p_y = comp[2][31:0];
        r.p_z = comp[3][31:0];
        return r;
    endfunction

    // offer one transaction; predicted result queued at acceptance
    // valid drops only while idling, so back to back offers stay high
    task automatic send_pair(qmn_pkg::in_t q);
        while (!no_idle && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rotation_queue.push_back(unit_product(q));
        @(negedge aclk);
    endtask

    // receiver: random stalls, plus the long hold-off
    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else if (no_idle) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 37);
    end

    // compare each result transaction against the oldest prediction
    always @(posedge aclk) begin
        qmn_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rotation_queue.size() == 0) begin
                $error("result with nothing expected: %h", m_data);
                errors++;
            end else begin
                want = rotation_queue.pop_front();
                if (m_data.p_w !== want.p_w) begin
                    $error("p_w expected %0d got %0d", want.p_w, m_data.p_w); errors++;
                end
                if (m_data.p_x !== want.p_x) begin
                    $error("p_x expected %0d got %0d", want.p_x, m_data.p_x); errors++;
                end
                if (m_data.p_y !== want.p_y) begin
                    $error("p_y expected %0d got %0d", want.p_y, m_data.p_y); errors++;
                end
                if (m_data.p_z !== want.p_z) begin
                    $error("p_z expected %0d got %0d", want.p_z, m_data.p_z); errors++;
                end
                if (m_data.zero_norm !== want.zero_norm) begin
                    $error("zero_norm expected %0b got %0b", want.zero_norm,
                           m_data.zero_norm);
                    errors++;
                end
            end
        end
    end

    function automatic qmn_pkg::in_t pack_pair(logic [31:0] aw, logic [31:0] ax,
                                               logic [31:0] ay, logic [31:0] az,
                                               logic [31:0] bw, logic [31:0] bx,
                                               logic [31:0] by, logic [31:0] bz);
        qmn_pkg::in_t q;
        q.a_w = aw; q.a_x = ax; q.a_y = ay; q.a_z = az;
        q.b_w = bw; q.b_x = bx; q.b_y = by; q.b_z = bz;
        return q;
    endfunction

    // a component drawn half the time near unit scale, else fully random, tiny or extreme
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(7) - 4;
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000;
        endcase
    endfunction

    function automatic qmn_pkg::in_t rand_pair();
        return pack_pair(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                         rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endfunction

    // extremes, zero product, identity, tiny values and rounding at floor
    task automatic test_directed();
        localparam logic [31:0] ONE = 32'h4000_0000;
        localparam logic [31:0] MIN = 32'h8000_0000;
        localparam logic [31:0] MAX = 32'h7fff_ffff;
        send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pack_pair(ONE, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pack_pair(ONE, 0, 0, 0, ONE, 0, 0, 0));
        send_pair(pack_pair(0, ONE, 0, 0, 0, ONE, 0, 0));
        send_pair(pack_pair(0, 0, ONE, 0, 0, 0, 0, ONE));
        send_pair(pack_pair(MIN, MIN, MIN, MIN, MIN, MIN, MIN, MIN));
        send_pair(pack_pair(MAX, MAX, MAX, MAX, MAX, MAX, MAX, MAX));
        send_pair(pack_pair(MIN, MAX, MIN, MAX, MAX, MIN, MAX, MIN));
        send_pair(pack_pair(MIN, 0, 0, 0, MIN, 0, 0, 0));
        send_pair(pack_pair(1, 0, 0, 0, 1, 0, 0, 0));
        send_pair(pack_pair(-1, 0, 0, 0, 1, 0, 0, 0));
        send_pair(pack_pair(1, 1, 1, 1, 1, 1, 1, 1));
        send_pair(pack_pair(-1, -1, -1, -1, 3, -2, 1, 0));
        send_pair(pack_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                            MAX, MIN, MAX, MIN));
        send_pair(pack_pair(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                            32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
        send_pair(pack_pair(ONE, ONE, 0, 0, ONE, -ONE, 0, 0));
    endtask

    // random pairs, with a gap-free stretch in the middle
    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            no_idle = (i >= count / 3) && (i < count / 2);
            send_pair(rand_pair());
        end
        no_idle = 1'b0;
    endtask

    // receiver stalls for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3 * LATENCY) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 2 * LATENCY; i++) send_pair(rand_pair());
        join
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(600);
        test_backpressure();
        test_random(540);
        s_valid <= 1'b0;
        while (rotation_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### quaternion_multiply_normalize.f
src/qmn_pkg.sv
src/quaternion_multiply_normalize.sv
src/qmn_checker.sv
test/quaternion_multiply_normalize_tb.sv
